### hdl/qpr_pkg.sv
// Shared types, constants and helper functions for the quaternion product and rotate unit.
package qpr_pkg;

  // Word format: signed fixed point, WORD_BITS wide with FRAC_BITS fraction bits.
  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 12;
  // A sum of four double-width products plus the rounding constant fits in this width.
  localparam int SUM_BITS = 2 * WORD_BITS + 2;

  typedef enum logic [1:0] {
    CMD_MUL  = 2'd0,
    CMD_CONJ = 2'd1,
    CMD_ROT  = 2'd2
  } cmd_e;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } quat_t;

  // Input item.
  typedef struct packed {
    logic [1:0] cmd;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      a_w;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      b_w;
  } op_t;

  // Result item.
  typedef struct packed {
    word_t r_x;
    word_t r_y;
    word_t r_z;
    word_t r_w;
    logic  overflow;
  } res_t;

  // Side information that travels alongside an item through the product units.
  typedef struct packed {
    logic [1:0] cmd;
    quat_t      conj;
    logic       conj_ovf;
    quat_t      t;
    logic       t_ovf;
  } side_t;

  // Negate one word, saturating the most negative value to the largest positive one.
  function automatic word_t neg_sat(word_t v);
    return (v == WORD_MIN) ? WORD_MAX : word_t'(-v);
  endfunction

  // Conjugate: negate the vector part, keep the scalar part.
  function automatic quat_t conjugate(quat_t a);
    quat_t c;
    c.x = neg_sat(a.x);
    c.y = neg_sat(a.y);
    c.z = neg_sat(a.z);
    c.w = a.w;
    return c;
  endfunction

  // True when conjugating saturates any vector component.
  function automatic logic conj_sat(quat_t a);
    return (a.x == WORD_MIN) || (a.y == WORD_MIN) || (a.z == WORD_MIN);
  endfunction

endpackage

### hdl/qpr_mul.sv
// Three-stage pipelined Hamilton product with rounding and saturation.
module qpr_mul
  import qpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       opd_valid,
  output logic       opd_ready,
  input  quat_t      a,
  input  quat_t      b,
  input  side_t      side,
  output logic       prod_valid,
  input  logic       prod_ready,
  output quat_t      q,
  output logic [3:0] ovf,
  output side_t      q_side
);

  localparam logic signed [SUM_BITS-1:0] RND =
    {{(SUM_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MAX =
    {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN =
    {{(SUM_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  logic v1, v2, v3;
  logic en1, en2, en3;
  side_t side1, side2, side3;

  word_t av [4];
  word_t bv [4];
  logic signed [2*WORD_BITS-1:0] p [4][4];
  logic signed [SUM_BITS-1:0]    e [4][4];
  logic signed [SUM_BITS-1:0]    acc [4];
  logic signed [SUM_BITS-1:0]    s2 [4];
  word_t      qv [4];
  logic [3:0] sat;
  quat_t      q3;
  logic [3:0] ovf3;

  // Each stage moves on when it is empty or the stage after it moves on.
  assign en3       = !v3 || prod_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign opd_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= opd_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Operand components indexed x, y, z, w.
  always_comb begin
    av[0] = a.x;
    av[1] = a.y;
    av[2] = a.z;
    av[3] = a.w;
    bv[0] = b.x;
    bv[1] = b.y;
    bv[2] = b.z;
    bv[3] = b.w;
  end

  // Stage one: all sixteen cross products at full double width.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p[i][j] <= av[i] * bv[j];
        end
      end
      side1 <= side;
    end
  end

  // Stage two: signed sums of four products, rounded to nearest and scaled.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = SUM_BITS'(p[i][j]);
      end
    end
    acc[0] = e[0][3] + e[3][0] - e[2][1] + e[1][2] + RND;
    acc[1] = e[1][3] + e[2][0] + e[3][1] - e[0][2] + RND;
    acc[2] = e[2][3] - e[1][0] + e[0][1] + e[3][2] + RND;
    acc[3] = e[3][3] - e[0][0] - e[1][1] - e[2][2] + RND;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 4; i++) begin
        s2[i] <= acc[i] >>> FRAC_BITS;
      end
      side2 <= side1;
    end
  end

  // Stage three: saturate each component to the word range.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s2[i] > SUM_MAX) begin
        qv[i]  = WORD_MAX;
        sat[i] = 1'b1;
      end else if (s2[i] < SUM_MIN) begin
        qv[i]  = WORD_MIN;
        sat[i] = 1'b1;
      end else begin
        qv[i]  = word_t'(s2[i]);
        sat[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      q3.x  <= qv[0];
      q3.y  <= qv[1];
      q3.z  <= qv[2];
      q3.w  <= qv[3];
      ovf3  <= sat;
      side3 <= side2;
    end
  end

  assign prod_valid = v3;
  assign q          = q3;
  assign ovf        = ovf3;
  assign q_side     = side3;

  // An accepted operand always occupies the first stage on the next cycle.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (opd_valid && opd_ready) |=> v1)
    else $error("qpr_mul: accepted operand did not enter the first stage");

  // Backpressure reaches the input only when every stage is full and the output is held.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !opd_ready |-> (v1 && v2 && v3 && !prod_ready))
    else $error("qpr_mul: input stalled with a free stage");

  // A full stage that cannot move on keeps its item.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !en2) |=> v2)
    else $error("qpr_mul: stalled item lost from the middle stage");

endmodule

### hdl/quaternion_product_rotate.sv
// Top level of the fixed-point quaternion product, conjugate and rotate unit.
//
// Usage: each item on the op channel carries a command and two quaternions a and b
// in signed Q3.12. Multiply returns a*b, conjugate returns conj(a), rotate returns
// a*v*conj(a) for v = (b_x, b_y, b_z, 0) with r_w forced to zero. Every component is
// rounded to nearest and saturated; overflow is set when any component saturates.
// An unused command returns all zeros. Exactly one result item leaves the res channel
// for every op item, in order.
//
// Both channels use valid and ready. An op item passes through three stages in the
// first product unit, three in the second, and then the output register. Throughput
// is one item per cycle while the receiver keeps res_ready high; every command goes
// through both product units, each with sixteen 16x16 multipliers, so items never
// contend. When the receiver stalls, items pack up stage by stage, and op_ready
// falls only once every stage and the output register are full. Reset empties the
// pipeline; no item is held across it and the block is ready in the cycle after
// reset is released.
module quaternion_product_rotate
  import qpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  op_t  op,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  quat_t      a_q, b_q;
  side_t      side0;
  logic       m1_valid, m1_ready;
  quat_t      m1_q;
  logic [3:0] m1_ovf;
  side_t      m1_side, side_mid;
  logic       m2_valid, m2_ready;
  quat_t      m2_q;
  logic [3:0] m2_ovf;
  side_t      m2_side;
  res_t       res_next;
  logic       res_en;

  // Operands of the first product; rotate drops the scalar part of b.
  always_comb begin
    a_q = '{x: op.a_x, y: op.a_y, z: op.a_z, w: op.a_w};
    b_q = '{x: op.b_x, y: op.b_y, z: op.b_z, w: op.b_w};
    if (op.cmd == CMD_ROT) begin
      b_q.w = '0;
    end
    side0.cmd      = op.cmd;
    side0.conj     = conjugate(a_q);
    side0.conj_ovf = conj_sat(a_q);
    side0.t        = '0;
    side0.t_ovf    = 1'b0;
  end

  // First product: a*b, or a*v for rotate.
  qpr_mul u_mul1 (
    .clk        (clk),
    .rst        (rst),
    .opd_valid  (op_valid),
    .opd_ready  (op_ready),
    .a          (a_q),
    .b          (b_q),
    .side       (side0),
    .prod_valid (m1_valid),
    .prod_ready (m1_ready),
    .q          (m1_q),
    .ovf        (m1_ovf),
    .q_side     (m1_side)
  );

  // Keep the first product alongside the item for the final selection.
  always_comb begin
    side_mid       = m1_side;
    side_mid.t     = m1_q;
    side_mid.t_ovf = |m1_ovf;
  end

  // Second product: t*conj(a), used by rotate.
  qpr_mul u_mul2 (
    .clk        (clk),
    .rst        (rst),
    .opd_valid  (m1_valid),
    .opd_ready  (m1_ready),
    .a          (m1_q),
    .b          (m1_side.conj),
    .side       (side_mid),
    .prod_valid (m2_valid),
    .prod_ready (m2_ready),
    .q          (m2_q),
    .ovf        (m2_ovf),
    .q_side     (m2_side)
  );

  // Result selection by command.
  always_comb begin
    res_next = '0;
    unique case (cmd_e'(m2_side.cmd))
      CMD_MUL: begin
        res_next.r_x      = m2_side.t.x;
        res_next.r_y      = m2_side.t.y;
        res_next.r_z      = m2_side.t.z;
        res_next.r_w      = m2_side.t.w;
        res_next.overflow = m2_side.t_ovf;
      end
      CMD_CONJ: begin
        res_next.r_x      = m2_side.conj.x;
        res_next.r_y      = m2_side.conj.y;
        res_next.r_z      = m2_side.conj.z;
        res_next.r_w      = m2_side.conj.w;
        res_next.overflow = m2_side.conj_ovf;
      end
      CMD_ROT: begin
        res_next.r_x      = m2_q.x;
        res_next.r_y      = m2_q.y;
        res_next.r_z      = m2_q.z;
        res_next.r_w      = '0;
        res_next.overflow = m2_side.t_ovf || (|m2_ovf[2:0]);
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // Output register; it refills in the same cycle that its item is taken.
  assign res_en   = !res_valid || res_ready;
  assign m2_ready = res_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_en) begin
      res_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      res <= res_next;
    end
  end

  // The input only stalls when the output register is full and held.
  a_top_stall: assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> (res_valid && !res_ready))
    else $error("quaternion_product_rotate: input stalled while the output could drain");

  // A finished item from the second unit is taken into the output register.
  a_top_load: assert property (@(posedge clk) disable iff (rst)
    (m2_valid && m2_ready) |=> res_valid)
    else $error("quaternion_product_rotate: result lost on its way to the output");

  // The first unit's result stays in place while the second unit is full.
  a_top_mid: assert property (@(posedge clk) disable iff (rst)
    (m1_valid && !m1_ready) |=> (m1_valid && $stable(m1_q)))
    else $error("quaternion_product_rotate: first product changed while stalled");

endmodule

### dv/quaternion_product_rotate_tb.sv
// Self-checking testbench for the quaternion product, conjugate and rotate unit.
module quaternion_product_rotate_tb;
  import qpr_pkg::*;

  // The command code that selects no operation.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int N_RANDOM = 1300;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_AT = 400;
  localparam int STALL_CYCLES = 100;

  // One product: the saturated quaternion and a saturation flag per component (x, y, z, w).
  typedef struct packed {
    quat_t      q;
    logic [3:0] sat;
  } prod_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic op_valid = 1'b0;
  logic op_ready;
  op_t  op = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  op_t  pending_ops[$];
  res_t predicted_res[$];

  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_ovf = 0;
  int n_cmd[4] = '{0, 0, 0, 0};
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned gap_next;
  int unsigned stall_left = 0;
  logic stall_done = 1'b0;
  res_t want;
  res_t exp_res;

  quaternion_product_rotate uut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #5 clk = ~clk;

  // Sign extension of one word to a wide integer.
  function automatic longint sx(word_t v);
    return longint'($signed(v));
  endfunction

  // Round a double-width sum to nearest, ties upwards.
  function automatic longint round_sum(longint s);
    return (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic out_of_range(longint v);
    return (v > sx(WORD_MAX)) || (v < sx(WORD_MIN));
  endfunction

  function automatic word_t sat_word(longint v);
    if (v > sx(WORD_MAX)) return WORD_MAX;
    if (v < sx(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  // Hamilton product a*b, each component rounded and saturated on its own.
  function automatic prod_t hamilton_prod(quat_t a, quat_t b);
    longint ax, ay, az, aw, bx, by, bz, bw;
    longint sum_x, sum_y, sum_z, sum_w;
    prod_t p;
    ax = sx(a.x); ay = sx(a.y); az = sx(a.z); aw = sx(a.w);
    bx = sx(b.x); by = sx(b.y); bz = sx(b.z); bw = sx(b.w);
    sum_x = round_sum(ax * bw + aw * bx - az * by + ay * bz);
    sum_y = round_sum(ay * bw + az * bx + aw * by - ax * bz);
    sum_z = round_sum(az * bw - ay * bx + ax * by + aw * bz);
    sum_w = round_sum(aw * bw - ax * bx - ay * by - az * bz);
    p.q.x = sat_word(sum_x);
    p.q.y = sat_word(sum_y);
    p.q.z = sat_word(sum_z);
    p.q.w = sat_word(sum_w);
    p.sat = {out_of_range(sum_x), out_of_range(sum_y), out_of_range(sum_z),
             out_of_range(sum_w)};
    return p;
  endfunction

  // Conjugate with saturating negation; the flag says whether any part saturated.
  function automatic prod_t conj_quat(quat_t a);
    prod_t p;
    p.q.x = sat_word(-sx(a.x));
    p.q.y = sat_word(-sx(a.y));
    p.q.z = sat_word(-sx(a.z));
    p.q.w = a.w;
    p.sat = {a.x == WORD_MIN, a.y == WORD_MIN, a.z == WORD_MIN, 1'b0};
    return p;
  endfunction

  // Expected result of one item.
  function automatic res_t predict_res(op_t o);
    quat_t a, b;
    prod_t t, c, r;
    res_t  e;
    a = '{x: o.a_x, y: o.a_y, z: o.a_z, w: o.a_w};
    b = '{x: o.b_x, y: o.b_y, z: o.b_z, w: o.b_w};
    e = '0;
    case (o.cmd)
      CMD_MUL: begin
        r = hamilton_prod(a, b);
        e = '{r_x: r.q.x, r_y: r.q.y, r_z: r.q.z, r_w: r.q.w, overflow: |r.sat};
      end
      CMD_CONJ: begin
        r = conj_quat(a);
        e = '{r_x: r.q.x, r_y: r.q.y, r_z: r.q.z, r_w: r.q.w, overflow: |r.sat};
      end
      CMD_ROT: begin
        // The scalar part of the vector is taken as zero, and saturation of the
        // conjugate itself never raises the flag.
        b.w = '0;
        t = hamilton_prod(a, b);
        c = conj_quat(a);
        r = hamilton_prod(t.q, c.q);
        e = '{r_x: r.q.x, r_y: r.q.y, r_z: r.q.z, r_w: '0,
              overflow: (|t.sat) | (|r.sat[3:1])};
      end
      default: e = '0;
    endcase
    return e;
  endfunction

  // Random word: full range, near unit magnitude, or a corner value.
  function automatic word_t rand_word(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'(int'($urandom_range(0, 8192)) - 4096);
      default: begin
        case ($urandom_range(0, 6))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return '0;
          3: return word_t'(-1);
          4: return word_t'(1);
          5: return word_t'(4096);
          default: return word_t'(-4096);
        endcase
      end
    endcase
  endfunction

  task automatic add_op(logic [1:0] cmd, word_t ax, word_t ay, word_t az, word_t aw,
                        word_t bx, word_t by, word_t bz, word_t bw);
    op_t o;
    o = '{cmd: cmd, a_x: ax, a_y: ay, a_z: az, a_w: aw,
          b_x: bx, b_y: by, b_z: bz, b_w: bw};
    pending_ops.push_back(o);
  endtask

  task automatic report_mismatch(string what, int idx, longint got, longint exp_val);
    $display("MISMATCH item %0d %s: got %0d, expected %0d", idx, what, got, exp_val);
    errors++;
  endtask

  // Sender: offers queued items one by one, with random gaps or, in some stretches, none.
  always @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      send_gap <= 0;
    end else if (!op_valid || op_ready) begin
      if (op_valid) begin
        want = predict_res(op);
        predicted_res.push_back(want);
        n_cmd[op.cmd] <= n_cmd[op.cmd] + 1;
        if (want.overflow) n_ovf <= n_ovf + 1;
        n_sent <= n_sent + 1;
      end
      if (send_gap != 0) begin
        op_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_ops.size() != 0) begin
        op       <= pending_ops.pop_front();
        op_valid <= 1'b1;
        send_gap <= ((n_sent / 200) % 3 == 1) ? 0 : $urandom_range(0, 7);
      end else begin
        op_valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver, so that the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && n_recv >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver: checks each result item against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      gap_next = (recv_gap != 0) ? recv_gap - 1 : 0;
      if (res_valid && res_ready) begin
        if (predicted_res.size() == 0) begin
          report_mismatch("unexpected result", n_recv, sx(res.r_x), 0);
        end else begin
          exp_res = predicted_res.pop_front();
          if (res.r_x !== exp_res.r_x)
            report_mismatch("r_x", n_recv, sx(res.r_x), sx(exp_res.r_x));
          if (res.r_y !== exp_res.r_y)
            report_mismatch("r_y", n_recv, sx(res.r_y), sx(exp_res.r_y));
          if (res.r_z !== exp_res.r_z)
            report_mismatch("r_z", n_recv, sx(res.r_z), sx(exp_res.r_z));
          if (res.r_w !== exp_res.r_w)
            report_mismatch("r_w", n_recv, sx(res.r_w), sx(exp_res.r_w));
          if (res.overflow !== exp_res.overflow)
            report_mismatch("overflow", n_recv, longint'(res.overflow),
                            longint'(exp_res.overflow));
        end
        n_recv   <= n_recv + 1;
        gap_next = ((n_recv / 170) % 3 == 2) ? 0 : $urandom_range(0, 7);
      end
      recv_gap  <= gap_next;
      res_ready <= (stall_left == 0) && (gap_next == 0);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int mode;
    int r;
    logic [1:0] cmd;

    // Directed items: corners of every operation.
    add_op(CMD_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
    add_op(CMD_MUL, 0, 0, 0, 4096, 1234, -567, 890, -4096);
    add_op(CMD_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
           WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    add_op(CMD_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
           WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    add_op(CMD_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
           WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    // Rounding ties, one above and one below zero.
    add_op(CMD_MUL, 0, 0, 0, 1, 0, 0, 0, 2048);
    add_op(CMD_MUL, 0, 0, 0, -1, 0, 0, 0, 2048);
    add_op(CMD_MUL, 4096, 0, 0, 0, 0, 4096, 0, 0);
    add_op(CMD_CONJ, 1000, -2000, 3000, -4000, 5, 6, 7, 8);
    // Negating the most negative value saturates; the scalar part passes as it is.
    add_op(CMD_CONJ, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0);
    add_op(CMD_CONJ, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
           WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    add_op(CMD_CONJ, WORD_MIN, 1, -1, 0, WORD_MAX, 0, 0, 0);
    add_op(CMD_ROT, 0, 0, 0, 4096, 4096, -8192, 12000, 777);
    add_op(CMD_ROT, 0, 0, 2896, 2896, 4096, 0, 0, WORD_MAX);
    add_op(CMD_ROT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
           WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    add_op(CMD_ROT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
           WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    // Conjugate saturation inside a rotation is not flagged on its own.
    add_op(CMD_ROT, WORD_MIN, 0, 0, 0, 1, 1, 1, 0);
    add_op(CMD_ROT, 8000, -8000, 8000, 8000, 20000, -20000, 20000, WORD_MIN);
    add_op(CMD_UNUSED, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
           WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    add_op(CMD_UNUSED, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
           WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);

    // Random items: mostly valid commands, with the unused code now and then.
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 15);
      cmd = (r == 15) ? CMD_UNUSED : 2'(r % 3);
      mode = $urandom_range(0, 3);
      if (mode == 3) begin
        add_op(cmd, rand_word($urandom_range(0, 2)), rand_word($urandom_range(0, 2)),
               rand_word($urandom_range(0, 2)), rand_word($urandom_range(0, 2)),
               rand_word($urandom_range(0, 2)), rand_word($urandom_range(0, 2)),
               rand_word($urandom_range(0, 2)), rand_word($urandom_range(0, 2)));
      end else begin
        add_op(cmd, rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode),
               rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, then for every result to come back.
    while (pending_ops.size() != 0 || op_valid) @(posedge clk);
    while (predicted_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_res.size() != 0)
      report_mismatch("results never arrived", n_recv, 0, predicted_res.size());

    $display("Checked %0d results: %0d products, %0d conjugates, %0d rotations, %0d unused.",
             n_recv, n_cmd[CMD_MUL], n_cmd[CMD_CONJ], n_cmd[CMD_ROT], n_cmd[CMD_UNUSED]);
    $display("%0d results saturated; one long receiver stall of %0d cycles was applied.",
             n_ovf, STALL_CYCLES);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
